// ===== rtl/wsc_pkg.sv =====
// Shared types, register indexes and character helpers for the word and substring counter.
`timescale 1ns / 1ps

package wsc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MATCH_MODE = 2'd0;
  localparam logic [1:0] REG_WORD_LEN   = 2'd1;
  localparam logic [1:0] REG_WORD_LOW   = 2'd2;
  localparam logic [1:0] REG_WORD_HIGH  = 2'd3;

  // Input item kinds carried on the input tuser bit
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Mode values
  localparam logic MODE_WORD    = 1'b0;
  localparam logic MODE_PATTERN = 1'b1;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Shift control handed to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } wsc_shift_t;

  // Pick byte i of the 16-byte search word
  function automatic logic [7:0] word_byte(input logic [127:0] word, input logic [3:0] i);
    word_byte = word[i*8 +: 8];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

// ===== rtl/wsc_cell.sv =====
// One window cell: holds one recent line byte and compares the byte entering it.
`timescale 1ns / 1ps

module wsc_cell
  import wsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  wsc_shift_t ctl,
  input  logic [7:0] byte_in,   // byte arriving from the newer neighbor
  input  logic [7:0] expected,  // word byte this position must hold
  input  logic       active,    // position lies inside the word length
  output logic [7:0] byte_q,
  output logic       ok
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // Compare the byte that lands here on this item
  assign ok = !active || (byte_in == expected);

  // Clear on newline or end of text, shift the neighbor's byte in on a text byte, else hold
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = 8'h00;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_q = byte_r;

endmodule

// ===== rtl/wsc_token.sv =====
// Token tracker: follows whitespace-separated tokens and flags an exact word match.
`timescale 1ns / 1ps

module wsc_token
  import wsc_pkg::*;
#(
  parameter int POS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             done,
  input  logic [7:0]       char_code,
  input  logic [POS_W-1:0] eff_len,
  input  logic [127:0]     word,
  output logic             word_hit
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             miss_r, miss_nxt;
  logic             close_tok;

  // A token closes on whitespace or end of text
  assign close_tok = done || is_space(char_code);
  assign word_hit  = close_tok && !miss_r && (eff_len != '0) && (pos_r == eff_len);

  // Advance on a matching letter or digit, drop the token on any other one
  always_comb begin
    pos_nxt  = pos_r;
    miss_nxt = miss_r;
    if (accept) begin
      if (close_tok) begin
        pos_nxt  = '0;
        miss_nxt = 1'b0;
      end else if (is_alnum(char_code)) begin
        if (!miss_r && (pos_r < eff_len) &&
            (char_code == word_byte(word, 4'(pos_r)))) begin
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          miss_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      miss_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      miss_r <= miss_nxt;
    end
  end

endmodule

// ===== rtl/word_and_substring_counter.sv =====
// Top level of the word and substring counter: config, window cell row, counter, output stage.
// The block takes one item per clock and returns exactly one result item per input item, in
// the cycle after acceptance, through an output register; input is accepted whenever that
// register is empty or being emptied, so a fully ready sink sees a sustained rate of one item
// per cycle. The recent bytes of the line sit in a row of MAX_WORD_BYTES cells that shift on
// every text byte but newline and each compare their incoming byte against the matching word
// byte, so the pattern check is a single parallel window compare; the token tracker and the
// saturating count also settle in the same cycle. There is no clearing pass: reset and end of
// text clear text state at once. Configuration must only be written while the block is idle.
`timescale 1ns / 1ps

module word_and_substring_counter
  import wsc_pkg::*;
#(
  parameter int MAX_WORD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] match_count
  output logic        out_tuser,  // [0] hit
  output logic        out_tlast,  // done_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int FILL_W = $clog2(MAX_WORD_BYTES + 1);

  // Configuration registers
  logic        mode_r;
  logic [4:0]  word_len_r;
  logic [63:0] word_low_r;
  logic [63:0] word_high_r;
  logic [127:0] word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_WORD;
      word_len_r  <= 5'd1;
      word_low_r  <= '0;
      word_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH_MODE: mode_r      <= cfg_wdata[0];
        REG_WORD_LEN:   word_len_r  <= cfg_wdata[4:0];
        REG_WORD_LOW:   word_low_r  <= cfg_wdata;
        REG_WORD_HIGH:  word_high_r <= cfg_wdata;
        default:        mode_r      <= mode_r;
      endcase
    end
  end

  assign word = {word_high_r, word_low_r};

  // Effective word length, clipped to the window size
  logic [FILL_W-1:0] eff_len;
  assign eff_len = (word_len_r > 5'(MAX_WORD_BYTES)) ? FILL_W'(MAX_WORD_BYTES)
                                                     : FILL_W'(word_len_r);

  // Input handshake
  logic       accept;
  logic       done;
  logic       is_lf;
  logic [7:0] char_code;
  logic       out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign done      = (in_tuser == ACT_END);
  assign char_code = in_tdata;
  assign is_lf     = (char_code == CHAR_LF);

  // Window cell row
  wsc_shift_t             win_ctl;
  logic [7:0]             cell_in  [MAX_WORD_BYTES];
  logic [7:0]             cell_q   [MAX_WORD_BYTES];
  logic [7:0]             cell_exp [MAX_WORD_BYTES];
  logic [MAX_WORD_BYTES-1:0] cell_ok;

  assign win_ctl.shift = accept && !done && !is_lf;
  assign win_ctl.clear = accept && (done || is_lf);

  for (genvar k = 0; k < MAX_WORD_BYTES; k++) begin : g_cell
    logic act;
    assign act         = (k < int'(eff_len));
    assign cell_in[k]  = (k == 0) ? char_code : cell_q[(k == 0) ? 0 : k - 1];
    assign cell_exp[k] = word_byte(word, 4'(int'(eff_len) - 1 - k));

    wsc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (win_ctl),
      .byte_in  (cell_in[k]),
      .expected (cell_exp[k]),
      .active   (act),
      .byte_q   (cell_q[k]),
      .ok       (cell_ok[k])
    );
  end

  // Line fill, saturating at the window size
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic              line_hit;

  assign fill_inc = (fill_r < FILL_W'(MAX_WORD_BYTES)) ? fill_r + FILL_W'(1) : fill_r;
  assign line_hit = !done && !is_lf && (eff_len != '0) && (fill_inc >= eff_len) && (&cell_ok);

  always_comb begin
    fill_nxt = fill_r;
    if (win_ctl.clear) begin
      fill_nxt = '0;
    end else if (win_ctl.shift) begin
      fill_nxt = fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Token tracker
  logic word_hit;

  wsc_token #(
    .POS_W (FILL_W)
  ) u_token (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .done      (done),
    .char_code (char_code),
    .eff_len   (eff_len),
    .word      (word),
    .word_hit  (word_hit)
  );

  // Select the counting tracker and bump the saturating count
  logic        hit;
  logic [31:0] count_r, count_upd, count_nxt;

  assign hit       = (mode_r == MODE_PATTERN) ? line_hit : word_hit;
  assign count_upd = (hit && (count_r != '1)) ? count_r + 32'd1 : count_r;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = done ? '0 : count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Output register
  logic [31:0] out_count_r;
  logic        out_hit_r;
  logic        out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_count_r <= count_upd;
      out_hit_r   <= hit;
      out_done_r  <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_hit_r;
  assign out_tlast  = out_done_r;

  // End of text leaves a cleared count and a final result waiting
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done |=> (count_r == '0) && (fill_r == '0) && out_tvalid && out_tlast)
    else $error("end of text did not clear state or report");

  // A reported hit always carries a nonzero count
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata != '0))
    else $error("hit reported with zero count");

  // The count never falls within a text
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !done |=> (count_r >= $past(count_r)))
    else $error("running count decreased");

  // Line fill stays within the window
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_WORD_BYTES))
    else $error("line fill beyond window size");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for word_and_substring_counter: directed texts, random texts, stalls.
`timescale 1ns / 1ps

module testbench;
  import wsc_pkg::*;

  localparam int WORD_SLOTS = 16;
  localparam int RUN_LIMIT  = 200000;

  // One result item of the counter
  typedef struct packed {
    logic [31:0] match_count;
    logic        hit;
    logic        done_res;
  } count_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] char_code
  logic        in_tuser;   // [0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] match_count
  logic        out_tuser;  // [0] hit
  logic        out_tlast;  // done_res
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  // Shadow of the configuration registers
  logic         cfg_mode;
  logic [4:0]   cfg_len;
  logic [127:0] cfg_word;

  // Shadow of the text state
  logic [7:0]  line_bytes [WORD_SLOTS];
  int          line_fill;
  int          token_pos;
  logic        token_bad;
  logic [31:0] match_total;

  count_result_t expected_counts [$];
  count_result_t seen_result;
  count_result_t want_result;

  int          mismatches = 0;
  int          items_sent = 0;
  int          hold_off_cycles = 0;
  bit          sender_idles = 1'b1;
  bit          sink_idles = 1'b1;
  bit          offering = 1'b0;
  int unsigned cycle_count = 0;

  word_and_substring_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int word_bytes_in_use();
    return (cfg_len > WORD_SLOTS) ? WORD_SLOTS : int'(cfg_len);
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void clear_text_state();
    int k;
    for (k = 0; k < WORD_SLOTS; k++) line_bytes[k] = 8'h00;
    line_fill = 0;
    token_pos = 0;
    token_bad = 1'b0;
    match_total = 32'd0;
  endfunction

  // End the current token; report whether it spelled the word
  function automatic logic close_token(input int n);
    logic ok;
    ok = !token_bad && n != 0 && token_pos == n;
    token_pos = 0;
    token_bad = 1'b0;
    return ok;
  endfunction

  function automatic count_result_t predict_count(input logic kind, input logic [7:0] code);
    count_result_t res;
    int n;
    int k;
    logic word_hit;
    logic line_hit;
    logic hit;
    n = word_bytes_in_use();
    word_hit = 1'b0;
    line_hit = 1'b0;
    if (kind == ACT_END) begin
      word_hit = close_token(n);
    end else begin
      // token tracker: blanks close, matching letters and digits advance, others spoil the token, the rest is ignored
      if (blank_char(code)) begin
        word_hit = close_token(n);
      end else if (word_char(code)) begin
        if (!token_bad && token_pos < n && code == cfg_word[token_pos*8 +: 8]) begin
          token_pos++;
        end else begin
          token_bad = 1'b1;
        end
      end
      // line tracker: newline empties the window, anything else shifts in
      if (code == CHAR_LF) begin
        for (k = 0; k < WORD_SLOTS; k++) line_bytes[k] = 8'h00;
        line_fill = 0;
      end else begin
        for (k = WORD_SLOTS - 1; k > 0; k--) line_bytes[k] = line_bytes[k-1];
        line_bytes[0] = code;
        if (line_fill < WORD_SLOTS) line_fill++;
        if (n != 0 && line_fill >= n) begin
          line_hit = 1'b1;
          for (k = 0; k < n; k++) begin
            if (line_bytes[k] != cfg_word[(n-1-k)*8 +: 8]) line_hit = 1'b0;
          end
        end
      end
    end
    hit = (cfg_mode == MODE_PATTERN) ? line_hit : word_hit;
    if (hit && match_total != 32'hFFFF_FFFF) match_total++;
    res.match_count = match_total;
    res.hit = hit;
    res.done_res = (kind == ACT_END);
    if (kind == ACT_END) clear_text_state();
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // Mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [127:0] pack_word(input string s);
    logic [127:0] w;
    int i;
    w = '0;
    for (i = 0; i < s.len() && i < WORD_SLOTS; i++) w[i*8 +: 8] = s[i];
    return w;
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] code);
    int gap;
    gap = sender_idles ? random_gap() : 0;
    if (gap > 0 && offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= code;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_counts.push_back(predict_count(kind, code));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i]);
  endtask

  // Stop offering and hold until every expected result is back
  task automatic wait_idle();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // Write all four registers while the block is idle; junk above the used bits
  task automatic load_config(input logic mode, input logic [4:0] len, input logic [127:0] word);
    logic [63:0] mode_value;
    logic [63:0] len_value;
    wait_idle();
    mode_value = {$urandom(), $urandom()};
    mode_value[0] = mode;
    len_value = {$urandom(), $urandom()};
    len_value[4:0] = len;
    cfg_we <= 1'b1;
    cfg_index <= REG_MATCH_MODE;
    cfg_wdata <= mode_value;
    @(posedge clk);
    cfg_index <= REG_WORD_LEN;
    cfg_wdata <= len_value;
    @(posedge clk);
    cfg_index <= REG_WORD_LOW;
    cfg_wdata <= word[63:0];
    @(posedge clk);
    cfg_index <= REG_WORD_HIGH;
    cfg_wdata <= word[127:64];
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_mode = mode;
    cfg_len = len;
    cfg_word = word;
  endtask

  // Random word over a small alphabet, now and then a digit, capital, dash, newline or any byte
  task automatic load_random_config();
    logic [127:0] w;
    logic [4:0] len;
    int r;
    int i;
    r = $urandom_range(0, 19);
    if (r == 0) len = 5'd0;
    else if (r == 1) len = 5'($urandom_range(17, 31));
    else if (r < 6) len = 5'($urandom_range(5, 16));
    else len = 5'($urandom_range(1, 4));
    for (i = 0; i < WORD_SLOTS; i++) begin
      r = $urandom_range(0, 39);
      if (r < 30) w[i*8 +: 8] = 8'("a" + $urandom_range(0, 1));
      else if (r < 33) w[i*8 +: 8] = 8'("0" + $urandom_range(0, 1));
      else if (r < 35) w[i*8 +: 8] = "A";
      else if (r < 37) w[i*8 +: 8] = "-";
      else if (r < 38) w[i*8 +: 8] = CHAR_LF;
      else w[i*8 +: 8] = 8'($urandom_range(0, 255));
    end
    load_config(1'($urandom_range(0, 1)), len, w);
  endtask

  // Text built from the word, its prefixes, separators and noise
  task automatic run_random_text(input int budget);
    string punct;
    int stop_at;
    int n;
    int r;
    int k;
    int cut;
    punct = ".,!'-";
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      n = word_bytes_in_use();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // whole word or a prefix, sometimes with punctuation slipped in
        if (r >= 30 && n > 0) n = $urandom_range(0, n - 1);
        cut = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, n)) : -1;
        for (k = 0; k <= n; k++) begin
          if (k == cut) send_item(ACT_BYTE, punct[$urandom_range(0, 4)]);
          if (k < n) send_item(ACT_BYTE, cfg_word[k*8 +: 8]);
        end
      end else if (r < 65) begin
        send_item(ACT_BYTE, ($urandom_range(0, 2) == 0) ? CHAR_SPACE
                                                         : 8'($urandom_range(9, 13)));
      end else if (r < 80) begin
        send_item(ACT_BYTE, 8'("a" + $urandom_range(0, 1)));
      end else if (r < 93) begin
        send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_item(ACT_END, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset values: word mode, one byte, word byte zero
  task automatic test_reset_defaults();
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_END, 8'hFF);
  endtask

  // Punctuation inside a token is dropped; end of text closes a pending token
  task automatic test_word_mode();
    load_config(MODE_WORD, 5'd3, pack_word("cat"));
    send_text("ca!t\t");
    send_text("cat");
    send_item(ACT_END, 8'h00);
  endtask

  // Overlapping hits, newline breaks a match, end of text reports no hit
  task automatic test_pattern_mode();
    load_config(MODE_PATTERN, 5'd2, pack_word("aa"));
    send_text("aaa\naa");
    send_item(ACT_END, 8'h00);
  endtask

  // Empty word never matches; oversize length acts as the full width
  task automatic test_length_edges();
    load_config(MODE_WORD, 5'd0, pack_word("a"));
    send_text("a ");
    load_config(MODE_PATTERN, 5'd31, pack_word("ab"));
    send_text("b");
  endtask

  // Many short texts under changing settings, some left open across a change
  task automatic test_random_texts();
    int phase;
    for (phase = 0; phase < 12; phase++) begin
      load_random_config();
      run_random_text($urandom_range(15, 45));
    end
  endtask

  // Sink holds off while the source keeps offering, so the input stalls
  task automatic test_backpressure();
    load_random_config();
    sender_idles = 1'b0;
    hold_off_cycles = 120;
    run_random_text(30);
    sender_idles = 1'b1;
  endtask

  // Full rate on both sides
  task automatic test_streaming();
    load_random_config();
    sender_idles = 1'b0;
    sink_idles = 1'b0;
    run_random_text(40);
    sender_idles = 1'b1;
    sink_idles = 1'b1;
  endtask

  // ---------------------------------------------------------------- sink and checker

  initial begin : sink
    forever begin
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (sink_idles && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (random_gap() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result.match_count = out_tdata;
      seen_result.hit = out_tuser;
      seen_result.done_res = out_tlast;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result count=%0d hit=%0b done=%0b", $time,
                 out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want_result = expected_counts.pop_front();
        if (seen_result.match_count !== want_result.match_count) begin
          $display("%0t: match_count expected %0d actual %0d", $time,
                   want_result.match_count, seen_result.match_count);
          mismatches++;
        end
        if (seen_result.hit !== want_result.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time,
                   want_result.hit, seen_result.hit);
          mismatches++;
        end
        if (seen_result.done_res !== want_result.done_res) begin
          $display("%0t: done_res expected %0b actual %0b", $time,
                   want_result.done_res, seen_result.done_res);
          mismatches++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_counts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    in_tuser <= ACT_BYTE;
    cfg_we <= 1'b0;
    cfg_index <= REG_MATCH_MODE;
    cfg_wdata <= 64'd0;
    cfg_mode = MODE_WORD;
    cfg_len = 5'd1;
    cfg_word = '0;
    clear_text_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_word_mode();
    test_pattern_mode();
    test_length_edges();
    test_random_texts();
    test_backpressure();
    test_streaming();

    // Drain, then give stray results a chance to show up
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wsc_pkg.sv
rtl/wsc_cell.sv
rtl/wsc_token.sv
rtl/word_and_substring_counter.sv
sim/testbench.sv
